FILE: rtl/assert_macros.svh
// Assertion macros for the port-level checker of the cookie tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define CKT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("cookie tokenizer assertion failed");

// Antecedent implies consequent in the next cycle.
`define CKT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cookie tokenizer assertion failed");

`endif

FILE: rtl/ckt_pkg.sv
// Types and character constants for the cookie header tokenizer.
package ckt_pkg;

  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VSKIP = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  typedef struct packed {
    logic               pair_valid;
    logic [START_W-1:0] key_start;
    logic [LEN_W-1:0]   key_len;
    logic [START_W-1:0] value_start;
    logic [LEN_W-1:0]   value_len;
    logic               end_of_string;
    logic               too_long;
  } ckt_result_t;

endpackage

FILE: rtl/ckt_in_reg.sv
// Input register stage holding one header byte until the parser takes it.
module ckt_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_byte,
  input  logic       take,
  output logic       held,
  output logic [7:0] held_byte
);

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= char_byte;
    end
  end

endmodule

FILE: rtl/ckt_parse.sv
// Per-byte tokenizer state machine and span computation.
module ckt_parse #(
  parameter int MAX_LEN = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          cur_byte,
  input  logic                fire,
  output logic                has_result,
  output ckt_pkg::ckt_result_t result
);
  import ckt_pkg::*;

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int SW = $clog2(MAX_LEN);

  logic [1:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic          ovf, ovf_next;
  logic [SW-1:0] key_begin, key_begin_next;
  logic [PW-1:0] key_finish, key_finish_next;
  logic [SW-1:0] value_begin, value_begin_next;
  logic [PW-1:0] trim_end, trim_end_next;

  logic          is_del, is_valdel, sat, eos, flag;
  logic [SW-1:0] s;
  logic [PW-1:0] s_plus, kb, klen, vlen;

  always_comb begin
    is_valdel = cur_byte inside {CH_EQ, CH_SP, CH_TAB, CH_FF, CH_CR, CH_LF};
    is_del    = is_valdel || (cur_byte == CH_SEMI);
    eos       = (cur_byte == CH_NUL);
    sat       = (pos >= PW'(MAX_LEN));
    s         = sat ? SW'(MAX_LEN - 1) : pos[SW-1:0];
    s_plus    = PW'(s) + PW'(1);
    flag      = ovf || (!eos && sat);
    kb        = PW'(key_begin);
    if (phase == PH_KEY) begin
      klen = (pos >= kb) ? (pos - kb) : '0;
    end else begin
      klen = key_finish - kb;
    end
    vlen = trim_end - PW'(value_begin);

    result.end_of_string = eos;
    result.too_long      = flag;
    if (phase == PH_LEAD) begin
      result.pair_valid  = 1'b0;
      result.key_start   = '0;
      result.key_len     = '0;
      result.value_start = '0;
      result.value_len   = '0;
    end else begin
      result.pair_valid  = 1'b1;
      result.key_start   = START_W'(key_begin);
      result.key_len     = LEN_W'(klen);
      result.value_start = (phase == PH_VALUE) ? START_W'(value_begin) : '0;
      result.value_len   = (phase == PH_VALUE) ? LEN_W'(vlen) : '0;
    end
    has_result = eos || ((cur_byte == CH_SEMI) && (phase != PH_LEAD));
  end

  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    ovf_next         = ovf;
    key_begin_next   = key_begin;
    key_finish_next  = key_finish;
    value_begin_next = value_begin;
    trim_end_next    = trim_end;
    if (eos) begin
      phase_next = PH_LEAD;
      pos_next   = '0;
      ovf_next   = 1'b0;
    end else begin
      ovf_next = flag;
      if (!sat) begin
        pos_next = pos + PW'(1);
      end
      case (phase)
        PH_LEAD: begin
          if (!is_del) begin
            key_begin_next = s;
            phase_next     = PH_KEY;
          end
        end
        PH_KEY: begin
          if (cur_byte == CH_SEMI) begin
            phase_next = PH_LEAD;
          end else if (cur_byte == CH_EQ) begin
            key_finish_next = pos;
            phase_next      = PH_VSKIP;
          end
        end
        PH_VSKIP: begin
          if (cur_byte == CH_SEMI) begin
            phase_next = PH_LEAD;
          end else if (!is_valdel) begin
            value_begin_next = s;
            trim_end_next    = s_plus;
            phase_next       = PH_VALUE;
          end
        end
        default: begin
          if (cur_byte == CH_SEMI) begin
            phase_next = PH_LEAD;
          end else if (cur_byte != CH_SP) begin
            trim_end_next = s_plus;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      pos   <= '0;
      ovf   <= 1'b0;
    end else if (fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      key_begin   <= key_begin_next;
      key_finish  <= key_finish_next;
      value_begin <= value_begin_next;
      trim_end    <= trim_end_next;
    end
  end

endmodule

FILE: rtl/cookie_header_tokenizer.sv
// Cookie header tokenizer top level: input register, parser, result register.
// A byte is held in the input register; its result is then stored in the result register.
// Throughput: one byte per cycle; bytes without a result never wait on out_ready.
// A byte with a result waits in the input register only while out_valid && !out_ready.
// Reset (rst, synchronous) empties both registers and returns the parser to offset 0.
module cookie_header_tokenizer #(
  parameter int MAX_LEN = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  char_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        pair_valid,
  output logic [ckt_pkg::START_W-1:0] key_start,
  output logic [ckt_pkg::LEN_W-1:0]   key_len,
  output logic [ckt_pkg::START_W-1:0] value_start,
  output logic [ckt_pkg::LEN_W-1:0]   value_len,
  output logic                        end_of_string,
  output logic                        too_long
);
  import ckt_pkg::*;

  logic        held, take, has_result, out_free;
  logic [7:0]  held_byte;
  ckt_result_t result, result_q;

  assign out_free = !out_valid || out_ready;
  assign take     = held && (!has_result || out_free);

  ckt_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_byte (char_byte),
    .take      (take),
    .held      (held),
    .held_byte (held_byte)
  );

  ckt_parse #(.MAX_LEN(MAX_LEN)) u_parse (
    .clk        (clk),
    .rst        (rst),
    .cur_byte   (held_byte),
    .fire       (take),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && has_result) begin
      result_q <= result;
    end
  end

  assign pair_valid    = result_q.pair_valid;
  assign key_start     = result_q.key_start;
  assign key_len       = result_q.key_len;
  assign value_start   = result_q.value_start;
  assign value_len     = result_q.value_len;
  assign end_of_string = result_q.end_of_string;
  assign too_long      = result_q.too_long;

endmodule

FILE: rtl/ckt_checker.sv
// Port-level checker for the cookie header tokenizer, bound to the top level.
`include "assert_macros.svh"

module ckt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        pair_valid,
  input logic [ckt_pkg::START_W-1:0] key_start,
  input logic [ckt_pkg::LEN_W-1:0]   key_len,
  input logic [ckt_pkg::LEN_W-1:0]   value_len
);

  `CKT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `CKT_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(key_len) && $stable(value_len))
  `CKT_ASSERT(a_empty_spans, clk, rst, !(out_valid && !pair_valid) || (key_start == 0 && key_len == 0 && value_len == 0))
  `CKT_ASSERT(a_value_needs_pair, clk, rst, !(out_valid && value_len != 0) || pair_valid)

endmodule

bind cookie_header_tokenizer ckt_checker u_ckt_checker (.*);

FILE: tb/sv/cookie_header_tokenizer_checker.sv
// Checker for the cookie header tokenizer: predicts every result transaction and compares it.
module cookie_header_tokenizer_checker #(
  parameter int MAX_LEN = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  char_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        pair_valid,
  input  logic [ckt_pkg::START_W-1:0] key_start,
  input  logic [ckt_pkg::LEN_W-1:0]   key_len,
  input  logic [ckt_pkg::START_W-1:0] value_start,
  input  logic [ckt_pkg::LEN_W-1:0]   value_len,
  input  logic                        end_of_string,
  input  logic                        too_long,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ckt_pkg::*;

  localparam int REPORT_LIMIT = 40;

  logic [1:0]         phase;
  logic [LEN_W-1:0]   position;
  logic [START_W-1:0] key_first;
  logic [LEN_W-1:0]   key_stop;
  logic [START_W-1:0] value_first;
  logic [LEN_W-1:0]   value_stop;
  logic               overflowed;

  ckt_result_t expected_pairs[$];
  ckt_result_t want;
  ckt_result_t got;

  function automatic logic is_value_sep(logic [7:0] b);
    return b == CH_EQ || b == CH_SP || b == CH_TAB || b == CH_FF || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic is_pair_sep(logic [7:0] b);
    return b == CH_SEMI || is_value_sep(b);
  endfunction

  task clear_parser();
    phase       = PH_LEAD;
    position    = '0;
    key_first   = '0;
    key_stop    = '0;
    value_first = '0;
    value_stop  = '0;
    overflowed  = 1'b0;
  endtask

  // Build the pair that is open in the current phase, ending at offset stop.
  function automatic ckt_result_t open_pair(logic [LEN_W-1:0] stop, logic eos);
    ckt_result_t r;
    r = '0;
    r.end_of_string = eos;
    r.too_long = overflowed;
    case (phase)
      PH_KEY: begin
        r.pair_valid = 1'b1;
        r.key_start  = key_first;
        r.key_len    = (stop >= LEN_W'(key_first)) ? stop - LEN_W'(key_first) : '0;
      end
      PH_VSKIP: begin
        r.pair_valid = 1'b1;
        r.key_start  = key_first;
        r.key_len    = key_stop - LEN_W'(key_first);
      end
      PH_VALUE: begin
        r.pair_valid  = 1'b1;
        r.key_start   = key_first;
        r.key_len     = key_stop - LEN_W'(key_first);
        r.value_start = value_first;
        r.value_len   = value_stop - LEN_W'(value_first);
      end
      default: ;
    endcase
    return r;
  endfunction

  task tokenize(logic [7:0] b);
    logic [LEN_W-1:0]   stop;
    logic [START_W-1:0] first;
    if (b == CH_NUL) begin
      expected_pairs.push_back(open_pair(position, 1'b1));
      clear_parser();
    end else begin
      stop = position;
      if (position >= MAX_LEN) begin
        overflowed = 1'b1;
        stop = LEN_W'(MAX_LEN);
      end
      first = (stop < MAX_LEN) ? stop[START_W-1:0] : START_W'(MAX_LEN - 1);
      case (phase)
        PH_LEAD: begin
          if (!is_pair_sep(b)) begin
            key_first = first;
            phase = PH_KEY;
          end
        end
        PH_KEY: begin
          if (b == CH_SEMI) begin
            expected_pairs.push_back(open_pair(stop, 1'b0));
            phase = PH_LEAD;
          end else if (b == CH_EQ) begin
            key_stop = stop;
            phase = PH_VSKIP;
          end
        end
        PH_VSKIP: begin
          if (b == CH_SEMI) begin
            expected_pairs.push_back(open_pair(stop, 1'b0));
            phase = PH_LEAD;
          end else if (!is_value_sep(b)) begin
            value_first = first;
            value_stop = LEN_W'(first) + 1'b1;
            phase = PH_VALUE;
          end
        end
        default: begin
          if (b == CH_SEMI) begin
            expected_pairs.push_back(open_pair(stop, 1'b0));
            phase = PH_LEAD;
          end else if (b != CH_SP) begin
            value_stop = LEN_W'(first) + 1'b1;
          end
        end
      endcase
      if (position < MAX_LEN) position = position + 1'b1;
    end
  endtask

  task compare_field(string field, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      fail_count = fail_count + 1;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_pairs.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {pair_valid, key_start, key_len, value_start, value_len, end_of_string, too_long};
        if (expected_pairs.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
        end else begin
          want = expected_pairs.pop_front();
          compare_field("pair_valid", want.pair_valid, got.pair_valid);
          compare_field("key_start", want.key_start, got.key_start);
          compare_field("key_len", want.key_len, got.key_len);
          compare_field("value_start", want.value_start, got.value_start);
          compare_field("value_len", want.value_len, got.value_len);
          compare_field("end_of_string", want.end_of_string, got.end_of_string);
          compare_field("too_long", want.too_long, got.too_long);
        end
      end
      if (in_valid && in_ready) tokenize(char_byte);
    end
    pending = expected_pairs.size();
  end

endmodule

FILE: tb/sv/cookie_header_tokenizer_tb.sv
// Testbench top for the cookie header tokenizer: header stimulus, handshake idling, verdict.
module cookie_header_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ckt_pkg::*;

  localparam int MAX_LEN     = 4096;
  localparam int QUIET_LIMIT = 1000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         char_byte;
  logic               out_valid;
  logic               out_ready;
  logic               pair_valid;
  logic [START_W-1:0] key_start;
  logic [LEN_W-1:0]   key_len;
  logic [START_W-1:0] value_start;
  logic [LEN_W-1:0]   value_len;
  logic               end_of_string;
  logic               too_long;

  int mismatches;
  int outstanding;
  int quiet_cycles;

  logic [7:0] header_bytes[$];

  cookie_header_tokenizer #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_byte(char_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pair_valid(pair_valid),
    .key_start(key_start),
    .key_len(key_len),
    .value_start(value_start),
    .value_len(value_len),
    .end_of_string(end_of_string),
    .too_long(too_long)
  );

  cookie_header_tokenizer_checker #(
    .MAX_LEN(MAX_LEN)
  ) pair_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_byte(char_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pair_valid(pair_valid),
    .key_start(key_start),
    .key_len(key_len),
    .value_start(value_start),
    .value_len(value_len),
    .end_of_string(end_of_string),
    .too_long(too_long),
    .fail_count(mismatches),
    .pending(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] token_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h21, 8'h3A));
      1: return 8'($urandom_range(8'h0E, 8'h1F));
      default: return 8'($urandom_range(8'h3E, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_FF;
      3: return CH_CR;
      4: return CH_LF;
      default: return CH_EQ;
    endcase
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) header_bytes.push_back(s[i]);
  endtask

  task automatic add_cookie();
    repeat ($urandom_range(0, 2)) header_bytes.push_back(blank_byte());
    repeat ($urandom_range(1, 8)) header_bytes.push_back(token_byte());
    if ($urandom_range(0, 4) != 0) begin
      header_bytes.push_back(CH_EQ);
      repeat ($urandom_range(0, 2)) header_bytes.push_back(blank_byte());
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 5) == 0)
          header_bytes.push_back($urandom_range(0, 1) ? CH_EQ : CH_SP);
        else
          header_bytes.push_back(token_byte());
      end
      repeat ($urandom_range(0, 2)) header_bytes.push_back(CH_SP);
    end
  endtask

  task automatic add_header(int min_len);
    int first;
    first = header_bytes.size();
    add_cookie();
    while (header_bytes.size() - first < min_len || $urandom_range(0, 2) != 0) begin
      repeat ($urandom_range(1, 3)) header_bytes.push_back(CH_SEMI);
      add_cookie();
    end
    if ($urandom_range(0, 3) == 0) header_bytes.push_back(CH_SEMI);
    header_bytes.push_back(CH_NUL);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(0, 20)) begin
      case ($urandom_range(0, 3))
        0: header_bytes.push_back(blank_byte());
        1: header_bytes.push_back(CH_SEMI);
        default: header_bytes.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    header_bytes.push_back(CH_NUL);
  endtask

  task automatic add_random(int count);
    int goal;
    goal = header_bytes.size() + count;
    while (header_bytes.size() < goal) begin
      if ($urandom_range(0, 3) == 0) add_noise();
      else add_header(0);
    end
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : drain
    int  stall;
    bit  drain_burst;
    drain_burst = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
      stall = drain_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int gap;
    bit send_burst;
    rst = 1'b1;
    in_valid = 1'b0;
    char_byte = '0;
    out_ready = 1'b0;
    quiet_cycles = 0;
    send_burst = 1'b0;

    header_bytes.push_back(CH_NUL);
    add_text(";\t=");
    header_bytes.push_back(CH_FF);
    header_bytes.push_back(CH_LF);
    header_bytes.push_back(CH_NUL);
    add_text("a=;;;k;x=");
    header_bytes.push_back(CH_CR);
    add_text(" v=w  ;");
    header_bytes.push_back(8'hFF);
    add_text("=");
    header_bytes.push_back(CH_NUL);
    add_text("k");
    header_bytes.push_back(CH_NUL);

    add_random(400);
    add_random(370);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (header_bytes[i]) begin
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      char_byte <= header_bytes[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
